@@ rtl/core/two_level_page_table_walk_macros.svh @@
// Assertion macros for the two-level page table walker.
`ifndef TWO_LEVEL_PAGE_TABLE_WALK_MACROS_SVH
`define TWO_LEVEL_PAGE_TABLE_WALK_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define TLPTW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define TLPTW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/tlptw_pkg.sv @@
// Shared types, constants and helpers for the two-level page table walker.
package tlptw_pkg;

    localparam int PAGE_COUNT = 128;
    localparam int PAGE_BYTES = 32;
    localparam int MEM_BYTES  = PAGE_COUNT * PAGE_BYTES;
    localparam int PAGE_W     = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int OFF_W      = $clog2(PAGE_BYTES);
    localparam int MEM_AW     = PAGE_W + OFF_W;

    localparam logic [7:0]  PAGE_LIMIT = 8'(PAGE_COUNT);
    localparam logic [12:0] MEM_LIMIT  = 13'(MEM_BYTES);

    localparam logic [6:0] DIR_PAGE_RESET = 7'd17;

    localparam logic CMD_LOAD      = 1'b0;
    localparam logic CMD_TRANSLATE = 1'b1;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_DIR_FAULT   = 2'd1;
    localparam logic [1:0] ST_TABLE_FAULT = 2'd2;
    localparam logic [1:0] ST_LOAD_DONE   = 2'd3;

    typedef struct packed {
        logic        command;
        logic [11:0] load_address;
        logic [7:0]  load_value;
        logic [14:0] virtual_address;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  directory_entry;
        logic [7:0]  table_entry;
        logic [11:0] physical_address;
        logic [7:0]  data_value;
    } rsp_t;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIR  = 4'b0010,
        S_TAB  = 4'b0100,
        S_DATA = 4'b1000
    } state_t;

    // True when the page lies inside the implemented memory.
    function automatic logic page_ok(input logic [6:0] page);
        return {1'b0, page} < PAGE_LIMIT;
    endfunction

    // Byte address of an offset within a page.
    function automatic logic [MEM_AW-1:0] mem_addr(input logic [6:0] page,
                                                   input logic [4:0] off);
        return {page[PAGE_W-1:0], off[OFF_W-1:0]};
    endfunction

endpackage

@@ rtl/core/tlptw_ram.sv @@
// Generic single-port RAM with a registered read.
module tlptw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/two_level_page_table_walk.sv @@
// Top level of the two-level page table walker.
//
//   Channel   Signals                      Direction  Handshake
//   request   start, busy, request         in         taken when start is high and busy low
//   result    done, result                 out        valid for the one cycle done is high
//   config    cfg_write, cfg_data          in         directory page written when cfg_write
//
// A load request writes its byte at the accepting edge; its result comes in the
// next cycle and the block stays ready, so loads go at one per cycle.
// A translate request holds busy through the directory, table and data states:
// the directory entry, table entry and data byte are three dependent reads
// through the single port of the physical memory. A fault ends the walk early.
// Reset clears the sequencer and sets the directory page to 17; the memory
// itself is not cleared. The receiver cannot stall, so results never wait.
`include "two_level_page_table_walk_macros.svh"

module two_level_page_table_walk (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  tlptw_pkg::req_t request,
    input  logic           cfg_write,
    input  logic [6:0]     cfg_data,
    output logic           done,
    output tlptw_pkg::rsp_t result
);

    import tlptw_pkg::*;

    state_t            state_reg, state_next;
    logic              done_reg, done_next;
    rsp_t              result_reg, result_next;
    logic [6:0]        dir_page_reg;
    logic              oor_reg, oor_next;
    logic [9:0]        va_reg, va_next;
    logic [7:0]        dir_entry_reg, dir_entry_next;
    logic [7:0]        tab_entry_reg, tab_entry_next;

    logic              ram_we;
    logic [MEM_AW-1:0] ram_addr;
    logic [7:0]        ram_rdata;
    logic [7:0]        entry;

    // The single memory port is shared by loads and all three walk reads.
    tlptw_ram #(
        .WIDTH (8),
        .DEPTH (MEM_BYTES)
    ) u_mem (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (request.load_value),
        .rdata (ram_rdata)
    );

    // A page beyond the implemented memory reads as zero, so its entry is invalid.
    assign entry = oor_reg ? 8'd0 : ram_rdata;

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    always_comb
    begin
        state_next     = state_reg;
        done_next      = 1'b0;
        result_next    = result_reg;
        oor_next       = 1'b0;
        va_next        = va_reg;
        dir_entry_next = dir_entry_reg;
        tab_entry_next = tab_entry_reg;
        ram_we         = 1'b0;
        ram_addr       = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (request.command == CMD_LOAD)
                    begin
                        // Loads beyond the memory are dropped but still answered.
                        ram_addr = request.load_address[MEM_AW-1:0];
                        ram_we   = ({1'b0, request.load_address} < MEM_LIMIT);
                        done_next                    = 1'b1;
                        result_next.status           = ST_LOAD_DONE;
                        result_next.directory_entry  = 8'd0;
                        result_next.table_entry      = 8'd0;
                        result_next.physical_address = 12'd0;
                        result_next.data_value       = 8'd0;
                    end
                    else
                    begin
                        // Start the walk with the directory entry read.
                        ram_addr   = mem_addr(dir_page_reg, request.virtual_address[14:10]);
                        oor_next   = !page_ok(dir_page_reg);
                        va_next    = request.virtual_address[9:0];
                        state_next = S_DIR;
                    end
                end
            end
            S_DIR:
            begin
                dir_entry_next = entry;
                if (!entry[7])
                begin
                    done_next                    = 1'b1;
                    result_next.status           = ST_DIR_FAULT;
                    result_next.directory_entry  = entry;
                    result_next.table_entry      = 8'd0;
                    result_next.physical_address = 12'd0;
                    result_next.data_value       = 8'd0;
                    state_next                   = S_IDLE;
                end
                else
                begin
                    ram_addr   = mem_addr(entry[6:0], va_reg[9:5]);
                    oor_next   = !page_ok(entry[6:0]);
                    state_next = S_TAB;
                end
            end
            S_TAB:
            begin
                tab_entry_next = entry;
                if (!entry[7])
                begin
                    done_next                    = 1'b1;
                    result_next.status           = ST_TABLE_FAULT;
                    result_next.directory_entry  = dir_entry_reg;
                    result_next.table_entry      = entry;
                    result_next.physical_address = 12'd0;
                    result_next.data_value       = 8'd0;
                    state_next                   = S_IDLE;
                end
                else
                begin
                    ram_addr   = mem_addr(entry[6:0], va_reg[4:0]);
                    oor_next   = !page_ok(entry[6:0]);
                    state_next = S_DATA;
                end
            end
            S_DATA:
            begin
                // The physical address is the frame times the page size plus the offset.
                done_next                    = 1'b1;
                result_next.status           = ST_OK;
                result_next.directory_entry  = dir_entry_reg;
                result_next.table_entry      = tab_entry_reg;
                result_next.physical_address = {tab_entry_reg[6:0], va_reg[4:0]};
                result_next.data_value       = entry;
                state_next                   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            done_reg     <= 1'b0;
            dir_page_reg <= DIR_PAGE_RESET;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (cfg_write)
            begin
                dir_page_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg    <= result_next;
        oor_reg       <= oor_next;
        va_reg        <= va_next;
        dir_entry_reg <= dir_entry_next;
        tab_entry_reg <= tab_entry_next;
    end

    // An accepted translation always begins with the directory read.
    `TLPTW_ASSERT_NEXT(a_walk_starts, start && !busy && request.command == CMD_TRANSLATE, state_reg == S_DIR, "translate request did not start a walk")

    // A walk result is only given once the sequencer is back at rest.
    `TLPTW_ASSERT_NOW(a_result_idle, done && result.status != ST_LOAD_DONE, !busy, "walk result while sequencer busy")

    // A directory fault reports nothing beyond the directory entry.
    `TLPTW_ASSERT_NOW(a_dir_fault_clean, done && result.status == ST_DIR_FAULT, result.table_entry == 8'd0 && result.physical_address == 12'd0 && result.data_value == 8'd0, "directory fault carries table or data fields")

endmodule
